### hdl/prtc_pkg.sv
// Shared types, widths and constants of the PID relay temperature controller.
// Used by every module in the hdl folder; depends on nothing else.
package prtc_pkg;

    // Field and datapath widths
    localparam int TEMP_W     = 16;
    localparam int MS_W       = 16;
    localparam int ERR_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int INT_W      = 14;
    localparam int ISUM_W     = 19;
    localparam int GAIN_W     = 16;
    localparam int DZ_W       = 15;
    localparam int DT_W       = 10;
    localparam int PUMP_W     = 16;
    localparam int PWM_W      = 7;
    localparam int DRIVE_W    = 16;
    localparam int MA_W       = 18;
    localparam int MB_W       = 17;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int ACC_W      = 45;
    localparam int SAT_W      = 24;

    // Shared divider: two quotient bits per cycle
    localparam int DIV_W           = 44;
    localparam int DIV_SHORT_W     = 26;
    localparam int DIV_STEPS_LONG  = DIV_W / 2;
    localparam int DIV_STEPS_SHORT = DIV_SHORT_W / 2;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS_LONG + 1);

    // Port widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Arithmetic constants
    localparam int INT_LIMIT   = 6400;
    localparam int SUM_LIMIT   = 6553600;
    localparam int DECAY_SHIFT = 10;
    localparam int DRIVE_SHIFT = 8;
    localparam logic [DT_W-1:0]   DECAY_MUL   = 10'd973;
    localparam logic [DT_W-1:0]   DEFAULT_DT  = 10'd100;
    localparam logic [MS_W-1:0]   MAX_DT      = 16'd1000;
    localparam logic [DT_W-1:0]   INT_DIV_DEN = 10'd1000;
    localparam logic [DT_W-1:0]   ROUND_BIAS  = 10'd500;
    localparam logic [DT_W-1:0]   MIN_DERIV_DT = 10'd2;
    localparam logic [PWM_W-1:0]  PWM_LAST    = 7'd99;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_START  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_RUN    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_REST   = 4'd7;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_P_RST     = 16'd256;
    localparam logic [GAIN_W-1:0] GAIN_I_RST     = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST     = 16'd0;
    localparam logic [TEMP_W-1:0] TARGET_RST     = 16'd0;
    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST  = 15'd512;
    localparam logic [PUMP_W-1:0] PUMP_START_RST = 16'd5;
    localparam logic [PUMP_W-1:0] PUMP_RUN_RST   = 16'd125;
    localparam logic [PUMP_W-1:0] PUMP_REST_RST  = 16'd60;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARM,
        S_DECAY,
        S_ERRDT,
        S_DIVI,
        S_DIVI_WAIT,
        S_MULP,
        S_MULI,
        S_MULD,
        S_DIVD,
        S_DIVD_WAIT,
        S_SUM,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_DECAY,
        MUL_ERRDT,
        MUL_P,
        MUL_I,
        MUL_D
    } mul_sel_t;

    typedef struct packed {
        logic     prep;
        logic     arm;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     decay;
        logic     div_start;
        logic     div_long;
        logic     int_upd;
        logic     acc_load;
        logic     acc_add_prod;
        logic     acc_add_div;
        logic     finish;
        logic     commit;
    } cmd_t;

    typedef struct packed {
        logic armed;
        logic dt_small;
        logic div_busy;
        logic div_done;
    } status_t;

endpackage

### hdl/prtc_div.sv
// Iterative unsigned divider, restoring, two quotient bits per cycle.
// Depends on prtc_pkg for its widths and step counts.
module prtc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         long_op,
    input  logic [prtc_pkg::DIV_W-1:0]   num,
    input  logic [prtc_pkg::DT_W-1:0]    den,
    output logic                         busy,
    output logic                         done,
    output logic [prtc_pkg::DIV_W-1:0]   quot
);
    import prtc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     work_reg;
    logic [DT_W-1:0]      rem_reg;
    logic [DT_W-1:0]      den_reg;

    logic [DT_W:0]        t1;
    logic [DT_W:0]        t2;
    logic [DT_W:0]        d1;
    logic [DT_W:0]        d2;
    logic                 ge1;
    logic                 ge2;
    logic [DT_W-1:0]      r1;
    logic [DT_W-1:0]      r2;

    // The remainder stays below the divisor, so it always fits the divisor width.
    always_comb
    begin
        t1  = {rem_reg, work_reg[DIV_W-1]};
        d1  = t1 - {1'b0, den_reg};
        ge1 = (t1 >= {1'b0, den_reg});
        r1  = ge1 ? d1[DT_W-1:0] : t1[DT_W-1:0];
        t2  = {r1, work_reg[DIV_W-2]};
        d2  = t2 - {1'b0, den_reg};
        ge2 = (t2 >= {1'b0, den_reg});
        r2  = ge2 ? d2[DT_W-1:0] : t2[DT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= long_op ? DIV_CNT_W'(DIV_STEPS_LONG) : DIV_CNT_W'(DIV_STEPS_SHORT);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // A short divide starts with its numerator in the top bits of the work register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            den_reg  <= den;
            work_reg <= long_op ? num : {num[DIV_SHORT_W-1:0], {(DIV_W-DIV_SHORT_W){1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_reg  <= r2;
            work_reg <= {work_reg[DIV_W-3:0], ge1, ge2};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = work_reg;

endmodule

### hdl/prtc_dp.sv
// Datapath of the temperature controller: configuration registers, PID arithmetic
// around one shared multiplier and divider, PWM and pump sequencing, result register.
// Depends on prtc_pkg and prtc_div.
module prtc_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [prtc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prtc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [prtc_pkg::IN_DATA_W-1:0]   in_data,
    input  prtc_pkg::cmd_t                   cmd,
    output prtc_pkg::status_t                status,
    output logic [prtc_pkg::OUT_DATA_W-1:0]  out_data
);
    import prtc_pkg::*;

    // Configuration registers
    logic [GAIN_W-1:0]        gain_p_reg;
    logic [GAIN_W-1:0]        gain_i_reg;
    logic [GAIN_W-1:0]        gain_d_reg;
    logic signed [TEMP_W-1:0] target_reg;
    logic [DZ_W-1:0]          dead_zone_reg;
    logic [PUMP_W-1:0]        pump_start_reg;
    logic [PUMP_W-1:0]        pump_run_reg;
    logic [PUMP_W-1:0]        pump_rest_reg;

    // Controller state
    logic signed [INT_W-1:0]  integral_reg;
    logic signed [ERR_W-1:0]  last_err_reg;
    logic                     armed_reg;
    logic [PWM_W-1:0]         pwm_count_reg;
    logic [PUMP_W-1:0]        pump_count_reg;
    logic                     pump_state_reg;

    // Working registers of one item
    logic signed [ERR_W-1:0]   err_reg;
    logic                      band_reg;
    logic [DT_W-1:0]           dt_reg;
    logic                      sec_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg;

    // Input item fields
    logic signed [TEMP_W-1:0] in_temp;
    logic [MS_W-1:0]          in_ms;
    logic                     in_sec;

    logic signed [ERR_W-1:0]  err_raw;
    logic [ERR_W-1:0]         err_mag;
    logic                     in_band;
    logic [DT_W-1:0]          dt_w;

    logic signed [DIFF_W-1:0] diff;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod_w;

    logic                     prod_neg;
    logic [PROD_W-1:0]        prod_mag;
    logic [PROD_W-1:0]        dec_shift;
    logic signed [INT_W-1:0]  dec_val;

    logic [DIV_SHORT_W-1:0]   int_num;
    logic [DIV_W-1:0]         der_base;
    logic [DIV_W-1:0]         der_num;
    logic [DIV_W-1:0]         div_num;
    logic [DT_W-1:0]          div_den;
    logic [DIV_W-1:0]         div_quot;
    logic                     div_busy;
    logic                     div_done;

    logic signed [ISUM_W-1:0] q_int;
    logic signed [ISUM_W-1:0] int_sum;
    logic signed [INT_W-1:0]  int_sat;

    logic signed [ACC_W-1:0]  q_acc;
    logic signed [SAT_W-1:0]  sum_sat;
    logic [SAT_W-1:0]         sat_mag;
    logic [SAT_W-1:0]         sat_shift;
    logic signed [DRIVE_W-1:0] drive_w;

    logic [PWM_W-1:0]         pwm_next;
    logic signed [DRIVE_W-1:0] neg_drive;
    logic                     heat;
    logic                     cool;
    logic [PUMP_W-1:0]        pump_cnt1;
    logic [PUMP_W:0]          stop_at;
    logic [PUMP_W-1:0]        pump_cnt_new;
    logic                     pump_state_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= GAIN_P_RST;
            gain_i_reg     <= GAIN_I_RST;
            gain_d_reg     <= GAIN_D_RST;
            target_reg     <= TARGET_RST;
            dead_zone_reg  <= DEAD_ZONE_RST;
            pump_start_reg <= PUMP_START_RST;
            pump_run_reg   <= PUMP_RUN_RST;
            pump_rest_reg  <= PUMP_REST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_P:     gain_p_reg     <= cfg_data;
                CFG_GAIN_I:     gain_i_reg     <= cfg_data;
                CFG_GAIN_D:     gain_d_reg     <= cfg_data;
                CFG_TARGET:     target_reg     <= cfg_data;
                CFG_DEAD_ZONE:  dead_zone_reg  <= cfg_data[DZ_W-1:0];
                CFG_PUMP_START: pump_start_reg <= cfg_data;
                CFG_PUMP_RUN:   pump_run_reg   <= cfg_data;
                CFG_PUMP_REST:  pump_rest_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Error, deadband and time step straight from the incoming item
    assign in_temp = in_data[TEMP_W-1:0];
    assign in_ms   = in_data[TEMP_W+MS_W-1:TEMP_W];
    assign in_sec  = in_data[TEMP_W+MS_W];

    always_comb
    begin
        err_raw = ERR_W'(target_reg) - ERR_W'(in_temp);
        err_mag = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : ERR_W'(err_raw);
        in_band = (err_mag <= {2'b00, dead_zone_reg});
        if ((in_ms == '0) || (in_ms > MAX_DT))
        begin
            dt_w = DEFAULT_DT;
        end
        else
        begin
            dt_w = in_ms[DT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            err_reg  <= in_band ? '0 : err_raw;
            band_reg <= in_band;
            dt_reg   <= dt_w;
            sec_reg  <= in_sec;
        end
    end

    // Shared signed multiplier, registered
    assign diff = DIFF_W'(err_reg) - DIFF_W'(last_err_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DECAY:
            begin
                mul_a = MA_W'(integral_reg);
                mul_b = MB_W'(DECAY_MUL);
            end
            MUL_ERRDT:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = MB_W'(dt_reg);
            end
            MUL_P:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = MB_W'(gain_p_reg);
            end
            MUL_I:
            begin
                mul_a = MA_W'(integral_reg);
                mul_b = MB_W'(gain_i_reg);
            end
            MUL_D:
            begin
                mul_a = MA_W'(diff);
                mul_b = MB_W'(gain_d_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_w = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod_w;
        end
    end

    // All divisions work on magnitudes; the sign comes back afterwards.
    always_comb
    begin
        prod_neg  = prod_reg[PROD_W-1];
        prod_mag  = prod_neg ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        dec_shift = prod_mag >> DECAY_SHIFT;
        dec_val   = prod_neg ? INT_W'(-dec_shift[INT_W-1:0]) : INT_W'(dec_shift[INT_W-1:0]);
        int_num   = prod_mag[DIV_SHORT_W-1:0] + DIV_SHORT_W'(ROUND_BIAS);
        // Times 1000 as 1024 - 16 - 8
        der_base  = DIV_W'(prod_mag);
        der_num   = (der_base << 10) - (der_base << 4) - (der_base << 3);
        div_num   = cmd.div_long ? der_num : DIV_W'(int_num);
        div_den   = cmd.div_long ? dt_reg : INT_DIV_DEN;
    end

    prtc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .long_op (cmd.div_long),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Integral update with saturation
    always_comb
    begin
        q_int   = {2'b00, div_quot[ERR_W-1:0]};
        int_sum = ISUM_W'(integral_reg) + (prod_neg ? -q_int : q_int);
        if (int_sum > INT_LIMIT)
        begin
            int_sat = INT_W'(INT_LIMIT);
        end
        else if (int_sum < -INT_LIMIT)
        begin
            int_sat = INT_W'(-INT_LIMIT);
        end
        else
        begin
            int_sat = int_sum[INT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
        end
        else if (cmd.decay && band_reg)
        begin
            integral_reg <= dec_val;
        end
        else if (cmd.int_upd)
        begin
            integral_reg <= int_sat;
        end
    end

    // Accumulator of the three terms
    assign q_acc = {1'b0, div_quot};

    always_ff @(posedge clk)
    begin
        if (cmd.acc_load)
        begin
            acc_reg <= ACC_W'(prod_reg);
        end
        else if (cmd.acc_add_prod)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        else if (cmd.acc_add_div)
        begin
            acc_reg <= acc_reg + (prod_neg ? -q_acc : q_acc);
        end
    end

    // Output saturation and scaling to Q8.8 percent
    always_comb
    begin
        if (acc_reg > SUM_LIMIT)
        begin
            sum_sat = SAT_W'(SUM_LIMIT);
        end
        else if (acc_reg < -SUM_LIMIT)
        begin
            sum_sat = SAT_W'(-SUM_LIMIT);
        end
        else
        begin
            sum_sat = acc_reg[SAT_W-1:0];
        end
        sat_mag   = sum_sat[SAT_W-1] ? SAT_W'(-sum_sat) : SAT_W'(sum_sat);
        sat_shift = sat_mag >> DRIVE_SHIFT;
        drive_w   = sum_sat[SAT_W-1] ? DRIVE_W'(-sat_shift[DRIVE_W-1:0])
                                     : DRIVE_W'(sat_shift[DRIVE_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.arm)
        begin
            drive_reg <= '0;
        end
        else if (cmd.finish)
        begin
            drive_reg <= drive_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg    <= 1'b0;
            last_err_reg <= '0;
        end
        else if (cmd.arm)
        begin
            armed_reg    <= 1'b1;
            last_err_reg <= '0;
        end
        else if (cmd.finish)
        begin
            last_err_reg <= err_reg;
        end
    end

    // Slow PWM and relays
    always_comb
    begin
        pwm_next  = (pwm_count_reg == PWM_LAST) ? '0 : pwm_count_reg + PWM_W'(1);
        neg_drive = -drive_reg;
        heat = !drive_reg[DRIVE_W-1] && (drive_reg != '0)
               && (pwm_next < drive_reg[DRIVE_W-2:DRIVE_SHIFT]);
        cool = drive_reg[DRIVE_W-1] && (pwm_next < neg_drive[DRIVE_W-2:DRIVE_SHIFT]);
    end

    // Pump sequence: off until the start count, on until the run end, then rest.
    always_comb
    begin
        pump_cnt1      = pump_count_reg + PUMP_W'(1);
        stop_at        = {1'b0, pump_run_reg} + {1'b0, pump_rest_reg};
        pump_cnt_new   = pump_count_reg;
        pump_state_new = pump_state_reg;
        if (sec_reg)
        begin
            pump_cnt_new = pump_cnt1;
            if (pump_cnt1 < pump_start_reg)
            begin
                pump_state_new = 1'b0;
            end
            else if (pump_cnt1 < pump_run_reg)
            begin
                pump_state_new = 1'b1;
            end
            else if ({1'b0, pump_cnt1} < stop_at)
            begin
                pump_state_new = 1'b0;
            end
            else
            begin
                pump_state_new = 1'b0;
                pump_cnt_new   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_count_reg  <= '0;
            pump_count_reg <= '0;
            pump_state_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            pwm_count_reg  <= pwm_next;
            pump_count_reg <= pump_cnt_new;
            pump_state_reg <= pump_state_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= {{(OUT_DATA_W-DRIVE_W-3-PWM_W){1'b0}},
                             pwm_next, pump_state_new, cool, heat, drive_reg};
        end
    end

    assign out_data        = out_data_reg;
    assign status.armed    = armed_reg;
    assign status.dt_small = (dt_reg < MIN_DERIV_DT);
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;

`ifndef SYNTHESIS
    a_integral_range: assert property (@(posedge clk) disable iff (!rst_n)
        (integral_reg <= INT_LIMIT) && (integral_reg >= -INT_LIMIT))
        else $error("integral accumulator outside its saturation limits");

    a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
        pwm_count_reg <= PWM_LAST)
        else $error("PWM counter beyond its last step");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (drive_reg <= 16'sd25600) && (drive_reg >= -16'sd25600))
        else $error("drive value outside plus or minus 100 percent");

    a_relays_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !(out_data_reg[DRIVE_W] && out_data_reg[DRIVE_W+1]))
        else $error("heater and cooler both on");
`endif

endmodule

### hdl/prtc_ctrl.sv
// Sequencer of the temperature controller: steps the datapath through one item
// and runs both stream handshakes. Depends on prtc_pkg.
module prtc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  prtc_pkg::status_t   status,
    output prtc_pkg::cmd_t      cmd
);
    import prtc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        m_valid_next  = m_valid_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.prep   = 1'b1;
                    state_next = status.armed ? S_DECAY : S_ARM;
                end
            end
            S_ARM:
            begin
                cmd.arm    = 1'b1;
                state_next = S_OUT;
            end
            S_DECAY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DECAY;
                state_next  = S_ERRDT;
            end
            S_ERRDT:
            begin
                cmd.decay   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ERRDT;
                state_next  = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVI_WAIT;
            end
            S_DIVI_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.int_upd = 1'b1;
                    state_next  = S_MULP;
                end
            end
            S_MULP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P;
                state_next  = S_MULI;
            end
            S_MULI:
            begin
                cmd.acc_load = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_I;
                state_next   = S_MULD;
            end
            S_MULD:
            begin
                cmd.acc_add_prod = 1'b1;
                cmd.mul_en       = 1'b1;
                cmd.mul_sel      = MUL_D;
                state_next       = S_DIVD;
            end
            S_DIVD:
            begin
                // A time step below two milliseconds drops the derivative term.
                if (status.dt_small)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_long  = 1'b1;
                    state_next    = S_DIVD_WAIT;
                end
            end
            S_DIVD_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.acc_add_div = 1'b1;
                    state_next      = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;

`ifndef SYNTHESIS
    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("new item taken while the previous one is in progress");

    a_div_free_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider restarted while busy");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(cmd.commit))
        else $error("result shown without a commit");
`endif

endmodule

### hdl/pid_relay_temperature_control_unit.sv
// Top level of the PID relay temperature controller.
// Joins the sequencer prtc_ctrl and the datapath prtc_dp; depends on prtc_pkg.
//
// Each input item is one control tick. The block takes one item at a time: a new
// tick is accepted only once the result of the last one is committed. The run time
// of an ordinary tick is set by the shared iterative divider, which yields two
// quotient bits a cycle: it rounds the integral increment and, unless the time step
// is below 2 ms, forms the derivative term, with steps of the one shared multiplier
// around them; the very first tick after reset only arms the controller. The result
// waits in an output register, and the next tick may be accepted while it does.
// Configuration writes are accepted in every cycle and must be made while no tick
// is in progress.
module pid_relay_temperature_control_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // temperature [15:0], elapsed_ms [31:16], second_passed [32], zeros [39:33]
    input  logic [prtc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // drive_value [15:0], heater_on [16], cooler_on [17], pump_on [18],
    // pwm_phase [25:19], zeros [31:26]
    output logic [prtc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [prtc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prtc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import prtc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    prtc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    prtc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_axis_tdata)
    );

endmodule

### tb/sv/pid_relay_temperature_control_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the PID relay temperature controller top level.
// Sends control ticks and register writes, predicts each result item and compares
// it; depends on prtc_pkg and pid_relay_temperature_control_unit.
module pid_relay_temperature_control_unit_tb;
    import prtc_pkg::*;

    localparam int RANDOM_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 250;
    localparam int SETTLE_CYCLES   = 60;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AT_RESULT  = 900;
    localparam int REPORT_LIMIT    = 10;
    localparam int MAX_IDLE        = 10;
    localparam int DIRECTED_ROWS   = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_PUMP_REST + 4'd1;

    typedef struct packed {
        logic [PWM_W-1:0]          pwm_phase;
        logic                      pump_on;
        logic                      cooler_on;
        logic                      heater_on;
        logic signed [DRIVE_W-1:0] drive_value;
    } tick_out_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [MS_W-1:0]          elapsed_ms;
        logic                     second_passed;
        logic                     fixed_answer;
        tick_out_t                answer;
    } tick_row_t;

    typedef struct packed {
        logic [GAIN_W-1:0]     gain_p;
        logic [GAIN_W-1:0]     gain_i;
        logic [GAIN_W-1:0]     gain_d;
        logic [TEMP_W-1:0]     target;
        logic [CFG_DATA_W-1:0] dead_zone;
        logic [PUMP_W-1:0]     pump_start;
        logic [PUMP_W-1:0]     pump_run;
        logic [PUMP_W-1:0]     pump_rest;
    } reg_set_t;

    logic                      clk;
    logic                      rst_n;
    logic [IN_DATA_W-1:0]      s_axis_tdata;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [OUT_DATA_W-1:0]     m_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    // Register copies and controller state as the predictor sees them.
    logic [GAIN_W-1:0]         gain_p_m     = GAIN_P_RST;
    logic [GAIN_W-1:0]         gain_i_m     = GAIN_I_RST;
    logic [GAIN_W-1:0]         gain_d_m     = GAIN_D_RST;
    logic signed [TEMP_W-1:0]  target_m     = TARGET_RST;
    logic [DZ_W-1:0]           dead_zone_m  = DEAD_ZONE_RST;
    logic [PUMP_W-1:0]         pump_start_m = PUMP_START_RST;
    logic [PUMP_W-1:0]         pump_run_m   = PUMP_RUN_RST;
    logic [PUMP_W-1:0]         pump_rest_m  = PUMP_REST_RST;

    logic signed [INT_W-1:0]   integral_m   = '0;
    logic signed [ERR_W-1:0]   last_error_m = '0;
    logic                      armed_m      = 1'b0;
    logic [PWM_W-1:0]          pwm_m        = '0;
    logic [PUMP_W-1:0]         pump_count_m = '0;
    logic                      pump_state_m = 1'b0;

    tick_out_t                 awaited_outputs[$];
    int                        mismatch_count = 0;
    bit                        idle_on = 1'b1;

    // Extremes and special cases; the answer is typed in only for the arming tick
    // and the two saturated ticks that follow it under the reset settings.
    tick_row_t directed_ticks [DIRECTED_ROWS] = '{
        '{16'sh7FFF, 16'hFFFF, 1'b0, 1'b1, {7'd1, 1'b0, 1'b0, 1'b0, 16'sh0000}},
        '{16'sh8000, 16'd100,  1'b0, 1'b1, {7'd2, 1'b0, 1'b0, 1'b1, 16'sh6400}},
        '{16'sh7FFF, 16'd1000, 1'b0, 1'b1, {7'd3, 1'b0, 1'b1, 1'b0, 16'sh9C00}},
        '{16'sh0000, 16'd0,    1'b1, 1'b0, '0},
        '{16'sh0200, 16'd1,    1'b0, 1'b0, '0},
        '{16'sh0201, 16'd2,    1'b1, 1'b0, '0},
        '{-16'sh0201, 16'd1001, 1'b1, 1'b0, '0},
        '{-16'sh00C8, 16'hFFFF, 1'b1, 1'b0, '0},
        '{16'sh0A00, 16'd999,  1'b1, 1'b0, '0},
        '{-16'sh0A00, 16'd1,   1'b1, 1'b0, '0},
        '{16'sh5555, 16'hAAAA, 1'b1, 1'b0, '0},
        '{16'shAAAA, 16'h5555, 1'b0, 1'b0, '0},
        '{16'sh0000, 16'd500,  1'b0, 1'b0, '0},
        '{16'sh03E8, 16'd50,   1'b0, 1'b0, '0}
    };

    pid_relay_temperature_control_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Division on the magnitude, so the quotient rounds toward zero unless a
    // bias is added first.
    function automatic longint div_on_magnitude(longint num, longint den, longint bias);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + bias) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic tick_out_t control_tick(logic signed [TEMP_W-1:0] temp,
                                               logic [MS_W-1:0] ms, logic sec);
        tick_out_t res;
        longint    dt;
        longint    err;
        longint    integ;
        longint    sum;
        longint    drive;
        longint    stop_at;
        drive = 0;
        if (!armed_m)
        begin
            armed_m = 1'b1;
            last_error_m = '0;
        end
        else
        begin
            dt = (ms == 0 || ms > 1000) ? 100 : longint'(ms);
            err = longint'(target_m) - longint'(temp);
            integ = longint'(integral_m);
            if (((err < 0) ? -err : err) <= longint'(dead_zone_m))
            begin
                err = 0;
                integ = div_on_magnitude(integ * 973, 1024, 0);
            end
            integ += div_on_magnitude(err * dt, 1000, 500);
            if (integ > 6400)
                integ = 6400;
            if (integ < -6400)
                integ = -6400;
            sum = longint'(gain_p_m) * err + longint'(gain_i_m) * integ;
            if (dt >= 2)
                sum += div_on_magnitude(longint'(gain_d_m) * (err - longint'(last_error_m))
                                        * 1000, dt, 0);
            if (sum > 6553600)
                sum = 6553600;
            if (sum < -6553600)
                sum = -6553600;
            drive = div_on_magnitude(sum, 256, 0);
            integral_m = INT_W'(integ);
            last_error_m = ERR_W'(err);
        end

        pwm_m = (pwm_m >= 7'd99) ? '0 : pwm_m + 7'd1;

        if (sec)
        begin
            stop_at = longint'(pump_run_m) + longint'(pump_rest_m);
            pump_count_m = pump_count_m + 1'b1;
            if (pump_count_m < pump_start_m)
                pump_state_m = 1'b0;
            else if (pump_count_m < pump_run_m)
                pump_state_m = 1'b1;
            else if (longint'(pump_count_m) < stop_at)
                pump_state_m = 1'b0;
            else
            begin
                pump_state_m = 1'b0;
                pump_count_m = '0;
            end
        end

        res.drive_value = DRIVE_W'(drive);
        res.heater_on   = (drive > 0) && (longint'(pwm_m) < drive / 256);
        res.cooler_on   = (drive < 0) && (longint'(pwm_m) < (-drive) / 256);
        res.pump_on     = pump_state_m;
        res.pwm_phase   = pwm_m;
        return res;
    endfunction

    // Leaves cfg_valid high so that back-to-back writes follow one another without a gap.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_GAIN_P:     gain_p_m     = value;
            CFG_GAIN_I:     gain_i_m     = value;
            CFG_GAIN_D:     gain_d_m     = value;
            CFG_TARGET:     target_m     = value;
            CFG_DEAD_ZONE:  dead_zone_m  = value[DZ_W-1:0];
            CFG_PUMP_START: pump_start_m = value;
            CFG_PUMP_RUN:   pump_run_m   = value;
            CFG_PUMP_REST:  pump_rest_m  = value;
            default: ;
        endcase
    endtask

    task automatic load_settings(reg_set_t s);
        write_reg(CFG_GAIN_P, s.gain_p);
        write_reg(CFG_GAIN_I, s.gain_i);
        write_reg(CFG_GAIN_D, s.gain_d);
        write_reg(CFG_TARGET, s.target);
        write_reg(CFG_DEAD_ZONE, s.dead_zone);
        write_reg(CFG_PUMP_START, s.pump_start);
        write_reg(CFG_PUMP_RUN, s.pump_run);
        write_reg(CFG_PUMP_REST, s.pump_rest);
        // An index past the register list must leave every setting alone.
        write_reg(CFG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 7)), CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tick(logic signed [TEMP_W-1:0] temp, logic [MS_W-1:0] ms,
                             logic sec, logic fixed, tick_out_t answer);
        tick_out_t predicted;
        int        gap;
        s_axis_tdata  <= {7'b0, sec, ms, temp};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = control_tick(temp, ms, sec);
        awaited_outputs.push_back(fixed ? answer : predicted);
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering ticks and waits until every result item is back and the
    // block has had time to finish any work in flight.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : tick_source
        reg_set_t                 settings;
        logic signed [TEMP_W-1:0] temp;
        logic [MS_W-1:0]          ms;
        logic                     sec;
        int                       spread;
        rst_n         <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tvalid <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_ticks[i])
            send_tick(directed_ticks[i].temperature, directed_ticks[i].elapsed_ms,
                      directed_ticks[i].second_passed, directed_ticks[i].fixed_answer,
                      directed_ticks[i].answer);
        drain_results();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                settings = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF, 16'hFFFF};
            else if (ph == 1)
                settings = '{16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000,
                             16'h0000, 16'h0000, 16'h0000};
            else
                settings = '{16'($urandom_range(0, 2048)), 16'($urandom_range(0, 1024)),
                             16'($urandom_range(0, 512)), 16'($urandom),
                             {1'($urandom_range(0, 1)), 15'($urandom_range(0, 1024))},
                             16'($urandom_range(0, 8)), 16'($urandom_range(0, 16)),
                             16'($urandom_range(0, 8))};
            load_settings(settings);
            idle_on = (ph % 3) != 2;
            spread = int'(dead_zone_m) + 1500;

            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                // Mostly readings around the setpoint so that the deadband and the
                // integral build-up are exercised; the rest spans the full range.
                if ($urandom_range(0, 9) < 6)
                    temp = TEMP_W'(int'(target_m) + $urandom_range(0, 2 * spread) - spread);
                else
                    temp = TEMP_W'($urandom);
                case ($urandom_range(0, 9))
                    0: ms = '0;
                    1: ms = MS_W'($urandom_range(1, 2));
                    2: ms = MS_W'($urandom_range(999, 1001));
                    3: ms = MS_W'($urandom);
                    default: ms = MS_W'($urandom_range(50, 300));
                endcase
                sec = 1'($urandom_range(0, 1));
                send_tick(temp, ms, sec, 1'b0, '0);
            end
            drain_results();
        end

        if (mismatch_count == 0 && awaited_outputs.size() == 0)
            $display("pid_relay_temperature_control_unit_tb passed");
        else
            $display("pid_relay_temperature_control_unit_tb failed");
        $finish;
    end

    initial
    begin : result_sink
        tick_out_t got;
        tick_out_t want;
        int        stall;
        int        taken;
        taken = 0;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            // One long hold-off lets the block fill up and push back on its input.
            if (taken == HOLD_AT_RESULT)
                stall = HOLD_CYCLES;
            else
                stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            got = m_axis_tdata[$bits(tick_out_t)-1:0];
            taken++;
            if (awaited_outputs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result item %0d arrived with none pending: %h", taken, got);
            end
            else
            begin
                want = awaited_outputs.pop_front();
                if (got.drive_value !== want.drive_value || got.heater_on !== want.heater_on
                    || got.cooler_on !== want.cooler_on || got.pump_on !== want.pump_on
                    || got.pwm_phase !== want.pwm_phase)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"result item %0d: expected drive %0d heat %0b cool %0b ",
                                  "pump %0b pwm %0d, got drive %0d heat %0b cool %0b ",
                                  "pump %0b pwm %0d"}, taken,
                                 want.drive_value, want.heater_on, want.cooler_on,
                                 want.pump_on, want.pwm_phase,
                                 got.drive_value, got.heater_on, got.cooler_on,
                                 got.pump_on, got.pwm_phase);
                end
            end
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("pid_relay_temperature_control_unit_tb failed");
        $finish;
    end

endmodule
